FILE: hdl/mlpemb_pkg.sv
`timescale 1ns / 1ps

package mlpemb_pkg;

  // Largest network the block holds; the memory depths and counter widths follow from these.
  localparam int MAX_INPUTS  = 64;
  localparam int MAX_HIDDEN  = 32;
  localparam int MAX_OUTPUTS = 16;

  // Field widths of the input and result items.
  localparam int REQ_W  = 3;
  localparam int SLOT_W = 11;
  localparam int VAL_W  = 16;
  localparam int IDX_W  = 4;
  localparam int OVAL_W = 15;

  // Stream data widths, padded to whole bytes.
  localparam int S_TDATA_W = 32;
  localparam int M_TDATA_W = 24;

  // Configuration register widths and port widths.
  localparam int NI_REG_W   = 7;
  localparam int NH_REG_W   = 6;
  localparam int NO_REG_W   = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  // Fixed-point constants.
  localparam int FRAC_W   = 12;
  localparam int ROUND_HF = 2048;
  localparam int Q_MAX    = 32767;
  localparam int QUO_W    = 16;

  // Request kinds carried on tuser.
  typedef enum logic [REQ_W-1:0] {
    REQ_W1   = 3'd0,
    REQ_B1   = 3'd1,
    REQ_W2   = 3'd2,
    REQ_B2   = 3'd3,
    REQ_FEAT = 3'd4
  } req_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NI = 2'd0,
    CFG_NH = 2'd1,
    CFG_NO = 2'd2
  } cfg_e;

endpackage

FILE: hdl/mlp_embedding_relu_l2norm.sv
`timescale 1ns / 1ps

// Channel   Direction  Ports                      Contents
// cfg       in         cfg_valid/ready/index/data register index, write data
// s_axis    in         tvalid/tready/tdata/tuser  tuser: req_type; tlast: final_feature
// m_axis    out        tvalid/tready/tdata/tlast  tlast: out_last
//
// Load and feature items are accepted only while the block is idle. A final
// feature starts a vector through the single shared multiply-accumulate pipe,
// then a square root and, unless the norm is zero, a division per result.
// Reset clears control state only; memory contents are undefined until loaded.
// Input is stalled for the whole vector; each result waits in the output
// register until its transfer completes.
module mlp_embedding_relu_l2norm (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [mlpemb_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mlpemb_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // [10:0] slot, [26:11] value, [31:27] zero
  input  logic [mlpemb_pkg::S_TDATA_W-1:0]  s_axis_tdata_i,
  // [2:0] req_type
  input  logic [mlpemb_pkg::REQ_W-1:0]      s_axis_tuser_i,
  input  logic                            s_axis_tlast_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // [3:0] out_index, [18:4] out_value, [23:19] zero
  output logic [mlpemb_pkg::M_TDATA_W-1:0]  m_axis_tdata_o,
  output logic                            m_axis_tlast_o
);
  import mlpemb_pkg::*;

  localparam int W1_DEPTH = MAX_HIDDEN * MAX_INPUTS;
  localparam int W2_DEPTH = MAX_OUTPUTS * MAX_HIDDEN;
  localparam int W1_AW = (W1_DEPTH > 1) ? $clog2(W1_DEPTH) : 1;
  localparam int W2_AW = (W2_DEPTH > 1) ? $clog2(W2_DEPTH) : 1;
  localparam int WA_W  = (W1_AW > W2_AW) ? W1_AW : W2_AW;
  localparam int FI_W  = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam int HI_W  = (MAX_HIDDEN > 1) ? $clog2(MAX_HIDDEN) : 1;
  localparam int OI_W  = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
  localparam int MAX_HO  = (MAX_HIDDEN > MAX_OUTPUTS) ? MAX_HIDDEN : MAX_OUTPUTS;
  localparam int MAX_DIM = (MAX_INPUTS > MAX_HO) ? MAX_INPUTS : MAX_HO;
  localparam int CNT_W = $clog2(MAX_DIM + 1);
  localparam int PROD_W = VAL_W + VAL_W + 1;
  localparam int ACC_W  = PROD_W + $clog2(MAX_DIM + 1) + 1;
  localparam int SQ_W   = ACC_W + (ACC_W % 2);
  localparam int NORM_W = SQ_W / 2;
  localparam int REM_W  = NORM_W + 3;
  localparam int SQC_W  = $clog2(NORM_W);
  localparam int NUM_W  = NORM_W + QUO_W;
  localparam int DVC_W  = $clog2(QUO_W);

  typedef enum logic [3:0] {
    S_IDLE, S_ISSUE, S_DRAIN, S_SQRT, S_ORD, S_DINIT, S_DIV, S_OUT
  } state_e;

  typedef enum logic [1:0] {PH_L1, PH_L2, PH_SQ} phase_e;

  // Control that travels with each multiply-accumulate step.
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last;
    logic [CNT_W-1:0] row;
  } tag_t;

  state_e state_q;
  phase_e phase_q;
  tag_t   t1_q, t2_q, t3_q;
  logic [CNT_W-1:0] row_q, col_q;
  logic [WA_W-1:0]  wa_q;
  logic [MAX_INPUTS-1:0] fvalid_q;
  logic [NI_REG_W-1:0] cfg_ni_q;
  logic [NH_REG_W-1:0] cfg_nh_q;
  logic [NO_REG_W-1:0] cfg_no_q;
  logic [SQC_W-1:0] sq_cnt_q;
  logic [DVC_W-1:0] div_cnt_q;
  logic m_valid_q;
  logic [OVAL_W-1:0] m_value_q;

  // Memories and their registered read data.
  logic signed [VAL_W-1:0] w1_mem [W1_DEPTH];
  logic signed [VAL_W-1:0] w2_mem [W2_DEPTH];
  logic signed [VAL_W-1:0] b1_mem [MAX_HIDDEN];
  logic signed [VAL_W-1:0] b2_mem [MAX_OUTPUTS];
  logic signed [VAL_W-1:0] f_mem  [MAX_INPUTS];
  logic [OVAL_W-1:0] h_mem [MAX_HIDDEN];
  logic [OVAL_W-1:0] o_mem [MAX_OUTPUTS];
  logic signed [VAL_W-1:0] w1_rd_q, w2_rd_q, b1_rd_q, b2_rd_q, f_rd_q;
  logic fv_rd_q;
  logic [OVAL_W-1:0] h_rd_q, o_rd_q;

  // Datapath registers.
  logic signed [PROD_W-1:0] p_q;
  logic signed [VAL_W-1:0]  bias2_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic [SQ_W-1:0]   sq_q;
  logic [REM_W-1:0]  rem_q;
  logic [NORM_W-1:0] root_q;
  logic [NORM_W-1:0] drem_q;
  logic [QUO_W-1:0]  dlow_q, quo_q;

  // Input decode.
  logic in_acc;
  req_e req;
  logic [SLOT_W-1:0] slot;
  logic signed [VAL_W-1:0] value;
  logic w1_we, w2_we, b1_we, b2_we, f_we, start;

  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;
  assign req    = req_e'(s_axis_tuser_i);
  assign slot   = s_axis_tdata_i[SLOT_W-1:0];
  assign value  = s_axis_tdata_i[SLOT_W +: VAL_W];
  assign w1_we  = in_acc && (req == REQ_W1) && (32'(slot) < W1_DEPTH);
  assign b1_we  = in_acc && (req == REQ_B1) && (32'(slot) < MAX_HIDDEN);
  assign w2_we  = in_acc && (req == REQ_W2) && (32'(slot) < W2_DEPTH);
  assign b2_we  = in_acc && (req == REQ_B2) && (32'(slot) < MAX_OUTPUTS);
  assign f_we   = in_acc && (req == REQ_FEAT) && (32'(slot) < MAX_INPUTS);
  assign start  = in_acc && (req == REQ_FEAT) && s_axis_tlast_i;

  // Clamp the configured sizes to 1..max.
  logic [CNT_W-1:0] ni, nh, no;
  always_comb begin
    if (cfg_ni_q == '0) ni = CNT_W'(1);
    else if (32'(cfg_ni_q) > MAX_INPUTS) ni = CNT_W'(MAX_INPUTS);
    else ni = CNT_W'(cfg_ni_q);
    if (cfg_nh_q == '0) nh = CNT_W'(1);
    else if (32'(cfg_nh_q) > MAX_HIDDEN) nh = CNT_W'(MAX_HIDDEN);
    else nh = CNT_W'(cfg_nh_q);
    if (cfg_no_q == '0) no = CNT_W'(1);
    else if (32'(cfg_no_q) > MAX_OUTPUTS) no = CNT_W'(MAX_OUTPUTS);
    else no = CNT_W'(cfg_no_q);
  end

  // Loop bounds and operand selection for the current phase.
  logic [CNT_W-1:0] rows_lim, cols_lim;
  logic signed [VAL_W-1:0]  a_op, bias_sel;
  logic signed [VAL_W:0]    b_op;
  always_comb begin
    case (phase_q)
      PH_L1: begin
        rows_lim = nh;
        cols_lim = ni;
        a_op     = w1_rd_q;
        b_op     = fv_rd_q ? (VAL_W+1)'(f_rd_q) : '0;
        bias_sel = b1_rd_q;
      end
      PH_L2: begin
        rows_lim = no;
        cols_lim = nh;
        a_op     = w2_rd_q;
        b_op     = $signed({2'b00, h_rd_q});
        bias_sel = b2_rd_q;
      end
      default: begin
        rows_lim = CNT_W'(1);
        cols_lim = no;
        a_op     = $signed({1'b0, o_rd_q});
        b_op     = $signed({2'b00, o_rd_q});
        bias_sel = '0;
      end
    endcase
  end

  logic last_col, last_row, drained, sqrt_start;
  assign last_col   = (col_q == cols_lim - CNT_W'(1));
  assign last_row   = (row_q == rows_lim - CNT_W'(1));
  assign drained    = !t1_q.valid && !t2_q.valid && !t3_q.valid;
  assign sqrt_start = (state_q == S_DRAIN) && drained && (phase_q == PH_SQ);

  // ReLU, rounding to unsigned Q3.12 and saturation of a finished sum.
  logic signed [ACC_W-1:0] rnd;
  logic [OVAL_W-1:0] fin_val;
  always_comb begin
    rnd = (acc_q + ACC_W'(ROUND_HF)) >>> FRAC_W;
    if (acc_q <= 0) fin_val = '0;
    else if (rnd > ACC_W'(Q_MAX)) fin_val = OVAL_W'(Q_MAX);
    else fin_val = rnd[OVAL_W-1:0];
  end

  logic h_we, o_we;
  assign h_we = t3_q.valid && t3_q.last && (phase_q == PH_L1);
  assign o_we = t3_q.valid && t3_q.last && (phase_q == PH_L2);

  // One square root step: two radicand bits in, one root bit out.
  logic [REM_W-1:0] rem_sh, trial;
  logic sq_ge;
  assign rem_sh = {rem_q[REM_W-3:0], sq_q[SQ_W-1 -: 2]};
  assign trial  = REM_W'({root_q, 2'b01});
  assign sq_ge  = rem_sh >= trial;

  // One restoring division step, and the rounded numerator for a new element.
  logic [NORM_W:0] dt;
  logic dge;
  logic [QUO_W-1:0] quo_nx;
  logic [NUM_W-1:0] num;
  assign dt     = {drem_q, dlow_q[QUO_W-1]};
  assign dge    = dt >= {1'b0, root_q};
  assign quo_nx = {quo_q[QUO_W-2:0], dge};
  assign num    = NUM_W'({o_rd_q, 15'b0}) + NUM_W'(root_q >> 1);

  logic [CNT_W-1:0] o_ra;
  assign o_ra = (state_q == S_ISSUE) ? col_q : row_q;

  // Weight and bias memories.
  always_ff @(posedge clk_i) begin
    if (w1_we) w1_mem[W1_AW'(slot)] <= value;
    w1_rd_q <= w1_mem[wa_q[W1_AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (w2_we) w2_mem[W2_AW'(slot)] <= value;
    w2_rd_q <= w2_mem[wa_q[W2_AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (b1_we) b1_mem[HI_W'(slot)] <= value;
    b1_rd_q <= b1_mem[row_q[HI_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (b2_we) b2_mem[OI_W'(slot)] <= value;
    b2_rd_q <= b2_mem[row_q[OI_W-1:0]];
  end

  // Feature memory; its valid bits live with the control state.
  always_ff @(posedge clk_i) begin
    if (f_we) f_mem[FI_W'(slot)] <= value;
    f_rd_q  <= f_mem[col_q[FI_W-1:0]];
    fv_rd_q <= fvalid_q[col_q[FI_W-1:0]];
  end

  // Hidden and output value memories.
  always_ff @(posedge clk_i) begin
    if (h_we) h_mem[t3_q.row[HI_W-1:0]] <= fin_val;
    h_rd_q <= h_mem[col_q[HI_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (o_we) o_mem[t3_q.row[OI_W-1:0]] <= fin_val;
    o_rd_q <= o_mem[o_ra[OI_W-1:0]];
  end

  // Shared multiply-accumulate, square root and divider datapath.
  always_ff @(posedge clk_i) begin
    if (t1_q.valid) begin
      p_q     <= a_op * b_op;
      bias2_q <= bias_sel;
    end
    if (t2_q.valid) begin
      acc_q <= (t2_q.first ? (ACC_W'(bias2_q) <<< FRAC_W) : acc_q) + ACC_W'(p_q);
    end
    if (sqrt_start) begin
      sq_q   <= SQ_W'(acc_q);
      rem_q  <= '0;
      root_q <= '0;
    end else if (state_q == S_SQRT) begin
      sq_q   <= sq_q << 2;
      rem_q  <= sq_ge ? rem_sh - trial : rem_sh;
      root_q <= {root_q[NORM_W-2:0], sq_ge};
    end
    if (state_q == S_DINIT) begin
      drem_q <= num[NUM_W-1:QUO_W];
      dlow_q <= num[QUO_W-1:0];
      quo_q  <= '0;
    end else if (state_q == S_DIV) begin
      drem_q <= dge ? NORM_W'(dt - {1'b0, root_q}) : NORM_W'(dt);
      dlow_q <= dlow_q << 1;
      quo_q  <= quo_nx;
    end
  end

  // Sequencer, configuration registers and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      phase_q   <= PH_L1;
      t1_q      <= '0;
      t2_q      <= '0;
      t3_q      <= '0;
      row_q     <= '0;
      col_q     <= '0;
      wa_q      <= '0;
      fvalid_q  <= '0;
      cfg_ni_q  <= NI_REG_W'(64);
      cfg_nh_q  <= NH_REG_W'(32);
      cfg_no_q  <= NO_REG_W'(16);
      sq_cnt_q  <= '0;
      div_cnt_q <= '0;
      m_valid_q <= 1'b0;
      m_value_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_e'(cfg_index_i))
          CFG_NI:  cfg_ni_q <= cfg_data_i[NI_REG_W-1:0];
          CFG_NH:  cfg_nh_q <= cfg_data_i[NH_REG_W-1:0];
          CFG_NO:  cfg_no_q <= cfg_data_i[NO_REG_W-1:0];
          default: ;
        endcase
      end
      if (f_we) fvalid_q[FI_W'(slot)] <= 1'b1;

      t2_q <= t1_q;
      t3_q <= t2_q;

      // Issue one multiply-accumulate step per cycle while a phase runs.
      if (state_q == S_ISSUE) begin
        t1_q <= '{valid: 1'b1, first: (col_q == '0), last: last_col, row: row_q};
      end else begin
        t1_q <= '0;
      end

      case (state_q)
        S_IDLE: begin
          if (start) begin
            state_q <= S_ISSUE;
            phase_q <= PH_L1;
            row_q   <= '0;
            col_q   <= '0;
            wa_q    <= '0;
          end
        end
        S_ISSUE: begin
          wa_q <= wa_q + WA_W'(1);
          if (last_col) begin
            col_q <= '0;
            row_q <= row_q + CNT_W'(1);
            if (last_row) begin
              state_q <= S_DRAIN;
              if (phase_q == PH_L1) fvalid_q <= '0;
            end
          end else begin
            col_q <= col_q + CNT_W'(1);
          end
        end
        S_DRAIN: begin
          if (drained) begin
            row_q <= '0;
            col_q <= '0;
            wa_q  <= '0;
            case (phase_q)
              PH_L1: begin
                phase_q <= PH_L2;
                state_q <= S_ISSUE;
              end
              PH_L2: begin
                phase_q <= PH_SQ;
                state_q <= S_ISSUE;
              end
              default: begin
                state_q  <= S_SQRT;
                sq_cnt_q <= '0;
              end
            endcase
          end
        end
        S_SQRT: begin
          sq_cnt_q <= sq_cnt_q + SQC_W'(1);
          if (sq_cnt_q == SQC_W'(NORM_W - 1)) begin
            state_q <= S_ORD;
            row_q   <= '0;
          end
        end
        S_ORD: begin
          state_q <= S_DINIT;
        end
        S_DINIT: begin
          if (root_q == '0) begin
            m_value_q <= '0;
            m_valid_q <= 1'b1;
            state_q   <= S_OUT;
          end else begin
            div_cnt_q <= '0;
            state_q   <= S_DIV;
          end
        end
        S_DIV: begin
          div_cnt_q <= div_cnt_q + DVC_W'(1);
          if (div_cnt_q == DVC_W'(QUO_W - 1)) begin
            m_value_q <= (quo_nx > QUO_W'(Q_MAX)) ? OVAL_W'(Q_MAX) : quo_nx[OVAL_W-1:0];
            m_valid_q <= 1'b1;
            state_q   <= S_OUT;
          end
        end
        S_OUT: begin
          if (m_axis_tready_i) begin
            m_valid_q <= 1'b0;
            if (row_q == no - CNT_W'(1)) begin
              state_q <= S_IDLE;
            end else begin
              row_q   <= row_q + CNT_W'(1);
              state_q <= S_ORD;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tlast_o  = (row_q == no - CNT_W'(1));
  assign m_axis_tdata_o  = {5'b0, m_value_q, IDX_W'(row_q)};

`ifndef ASSERT_OFF
  // The MAC pipe only carries work while a layer or the square sum runs.
  a_pipe_in_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    t3_q.valid |-> (state_q == S_ISSUE || state_q == S_DRAIN))
    else $error("MAC pipe active outside a compute phase");

  // No new item is taken while a result waits.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !m_axis_tvalid_o)
    else $error("input ready while a result is pending");

  // The last result transfer returns the block to idle.
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o) |=> s_axis_tready_o)
    else $error("block not idle after last result");

  // Division only runs with a nonzero norm.
  a_div_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (root_q != '0))
    else $error("division by a zero norm");
`endif

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import mlpemb_pkg::*;

  localparam int N_IN     = MAX_INPUTS;
  localparam int N_HID    = MAX_HIDDEN;
  localparam int N_OUT    = MAX_OUTPUTS;
  localparam int W1_SLOTS = N_HID * N_IN;
  localparam int W2_SLOTS = N_OUT * N_HID;
  localparam int RAND_ITEMS = 90;
  localparam int SETTLE_CYC = 40;
  localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd5;
  localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;

  typedef struct {
    logic [REQ_W-1:0]  kind;
    logic [SLOT_W-1:0] slot;
    logic [VAL_W-1:0]  val;
    logic              fin;
  } feed_t;

  typedef struct {
    logic [IDX_W-1:0]  idx;
    logic [OVAL_W-1:0] val;
    logic              last;
  } emb_elem_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_valid = 1'b0;
  logic                  s_ready;
  logic [S_TDATA_W-1:0]  s_data = '0;
  logic [REQ_W-1:0]      s_user = '0;
  logic                  s_last = 1'b0;
  logic                  m_valid;
  logic                  m_ready = 1'b0;
  logic [M_TDATA_W-1:0]  m_data;
  logic                  m_last;

  mlp_embedding_relu_l2norm i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .s_axis_tuser_i (s_user),
    .s_axis_tlast_i (s_last),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data),
    .m_axis_tlast_o (m_last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow state of the embedding engine.
  shortint w1_mem [W1_SLOTS];
  shortint b1_mem [N_HID];
  shortint w2_mem [W2_SLOTS];
  shortint b2_mem [N_OUT];
  shortint feat_buf [N_IN];
  longint  hid_val [N_HID];
  longint  emb_raw [N_OUT];
  logic [NI_REG_W-1:0] ni_reg = 7'd64;
  logic [NH_REG_W-1:0] nh_reg = 6'd32;
  logic [NO_REG_W-1:0] no_reg = 5'd16;

  feed_t     feed_q[$];
  emb_elem_t emb_q[$];
  int        err_cnt = 0;
  int        rand_items = 0;
  bit        gap_on = 1'b0;
  bit        stall_on = 1'b0;

  function automatic int clamp_dim(int v, int maxv);
    if (v == 0) return 1;
    return (v > maxv) ? maxv : v;
  endfunction

  // ReLU, round from Q.24 down to Q.12 and saturate.
  function automatic longint relu_round(longint acc);
    longint r;
    if (acc <= 0) return 0;
    r = (acc + ROUND_HF) >>> FRAC_W;
    return (r > Q_MAX) ? Q_MAX : r;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res = 0;
    longint unsigned b = 64'h4000_0000_0000_0000;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // Apply one accepted item and queue the embedding it produces, if any.
  function automatic void embed_predict(feed_t it);
    int ni, nh, no;
    longint acc;
    longint unsigned sumsq, norm, r;
    emb_elem_t e;
    case (it.kind)
      REQ_W1:   if (it.slot < W1_SLOTS) w1_mem[it.slot] = it.val;
      REQ_B1:   if (it.slot < N_HID) b1_mem[it.slot] = it.val;
      REQ_W2:   if (it.slot < W2_SLOTS) w2_mem[it.slot] = it.val;
      REQ_B2:   if (it.slot < N_OUT) b2_mem[it.slot] = it.val;
      REQ_FEAT: if (it.slot < N_IN) feat_buf[it.slot] = it.val;
      default: ;
    endcase
    if (it.kind != REQ_FEAT || !it.fin) return;
    ni = clamp_dim(int'(ni_reg), N_IN);
    nh = clamp_dim(int'(nh_reg), N_HID);
    no = clamp_dim(int'(no_reg), N_OUT);
    for (int i = 0; i < nh; i++) begin
      acc = longint'(b1_mem[i]) * 4096;
      for (int j = 0; j < ni; j++)
        acc += longint'(w1_mem[i*ni + j]) * longint'(feat_buf[j]);
      hid_val[i] = relu_round(acc);
    end
    sumsq = 0;
    for (int i = 0; i < no; i++) begin
      acc = longint'(b2_mem[i]) * 4096;
      for (int j = 0; j < nh; j++)
        acc += longint'(w2_mem[i*nh + j]) * hid_val[j];
      emb_raw[i] = relu_round(acc);
      sumsq += emb_raw[i] * emb_raw[i];
    end
    norm = int_sqrt(sumsq);
    for (int i = 0; i < no; i++) begin
      r = emb_raw[i];
      if (norm != 0) begin
        r = (r * 32768 + norm / 2) / norm;
        if (r > Q_MAX) r = Q_MAX;
      end
      e.idx = IDX_W'(i);
      e.val = r[OVAL_W-1:0];
      e.last = (i + 1 == no);
      emb_q.push_back(e);
    end
    foreach (feat_buf[k]) feat_buf[k] = 0;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 65) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Input driver: one item per transfer, with random gaps between transfers while gap_on is set.
  int gap_cnt = 0;
  feed_t cur_item;
  always @(posedge clk) begin
    feed_t nx;
    if (s_valid && s_ready) embed_predict(cur_item);
    if (!(s_valid && !s_ready)) begin
      if (gap_cnt > 0) begin
        gap_cnt <= gap_cnt - 1;
        s_valid <= 1'b0;
      end else if (rst_n && feed_q.size() > 0) begin
        nx = feed_q.pop_front();
        cur_item <= nx;
        s_valid <= 1'b1;
        s_user <= nx.kind;
        s_data <= {5'd0, nx.val, nx.slot};
        s_last <= nx.fin;
        gap_cnt <= gap_on ? pick_gap() : 0;
      end else begin
        s_valid <= 1'b0;
      end
    end
  end

  task automatic report_mismatch(string what, int got, int exp_v);
    if (err_cnt < 30)
      $display("mismatch %s: got %0d, expected %0d at %0t", what, got, exp_v, $time);
    err_cnt++;
  endtask

  // Result monitor with random backpressure while stall_on is set.
  int stall_cnt = 0;
  always @(posedge clk) begin
    emb_elem_t e;
    if (m_valid && m_ready) begin
      if (emb_q.size() == 0) begin
        report_mismatch("unexpected result, index", int'(m_data[IDX_W-1:0]), -1);
      end else begin
        e = emb_q.pop_front();
        if (m_data[IDX_W-1:0] != e.idx)
          report_mismatch("out_index", int'(m_data[IDX_W-1:0]), int'(e.idx));
        if (m_data[IDX_W +: OVAL_W] != e.val)
          report_mismatch("out_value", int'(m_data[IDX_W +: OVAL_W]), int'(e.val));
        if (m_last != e.last) report_mismatch("out_last", int'(m_last), int'(e.last));
      end
    end
    if (stall_cnt > 0) begin
      stall_cnt <= stall_cnt - 1;
      m_ready <= 1'b0;
    end else begin
      m_ready <= rst_n;
      stall_cnt <= stall_on ? pick_gap() : 0;
    end
  end

  task automatic push_item(logic [REQ_W-1:0] kind, int slot, int val, bit fin);
    feed_t it;
    it.kind = kind;
    it.slot = SLOT_W'(slot);
    it.val = VAL_W'(val);
    it.fin = fin;
    feed_q.push_back(it);
  endtask

  // Mostly moderate values so results stay off the rails; sometimes full range.
  function automatic int rand_val();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 65535);
    return $urandom_range(0, 8191) - 4096;
  endfunction

  task automatic wait_drained();
    while (feed_q.size() != 0 || s_valid || emb_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(cfg_e idx, int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(val);
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_NI: ni_reg = NI_REG_W'(val);
      CFG_NH: nh_reg = NH_REG_W'(val);
      CFG_NO: no_reg = NO_REG_W'(val);
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_dims(int ni, int nh, int no);
    write_reg(CFG_NI, ni);
    write_reg(CFG_NH, nh);
    write_reg(CFG_NO, no);
  endtask

  // One feature vector in slot order; the final item starts the computation.
  task automatic send_vector(int ni, bit count_it);
    for (int j = 0; j < ni; j++) begin
      push_item(REQ_FEAT, j, rand_val(), j == ni - 1);
      if (count_it) rand_items++;
    end
  endtask

  // Random weight and bias rewrites plus a few items the block ignores.
  task automatic send_noise(int n);
    int p;
    for (int k = 0; k < n; k++) begin
      p = $urandom_range(0, 9);
      case (p)
        0, 1: push_item(REQ_W1, $urandom_range(0, W1_SLOTS - 1), rand_val(),
                        1'($urandom_range(0, 1)));
        2, 3: push_item(REQ_W2, $urandom_range(0, W2_SLOTS - 1), rand_val(), 1'b0);
        4:    push_item(REQ_B1, $urandom_range(0, N_HID - 1), rand_val(), 1'b0);
        5:    push_item(REQ_B2, $urandom_range(0, N_OUT - 1), rand_val(), 1'b0);
        6:    push_item(REQ_W2, $urandom_range(W2_SLOTS, 2047), rand_val(), 1'b0);
        7:    push_item(REQ_FEAT, $urandom_range(N_IN, 2047), rand_val(), 1'b0);
        default: push_item(REQ_W'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI)),
                           $urandom_range(0, 2047), rand_val(),
                           1'($urandom_range(0, 1)));
      endcase
      if (p < 6) rand_items++;
    end
  endtask

  initial begin
    int ni, nh, no, nvec;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Load every weight and bias that the directed and random runs read:
    // one full layer-one row, all hidden units with one input, and all
    // outputs with one hidden unit.
    gap_on = 1'b1;
    stall_on = 1'b1;
    for (int k = 0; k < N_IN; k++) push_item(REQ_W1, k, rand_val(), 1'b0);
    for (int k = 0; k < N_HID; k++) push_item(REQ_B1, k, rand_val(), 1'b0);
    for (int k = 0; k < N_HID; k++) push_item(REQ_W2, k, rand_val(), 1'b0);
    for (int k = 0; k < N_OUT; k++) push_item(REQ_B2, k, rand_val(), 1'b0);
    wait_drained();

    // Directed: single-unit network with extreme values and odd items.
    set_dims(1, 1, 1);
    push_item(REQ_W1, 0, 16'h7FFF, 1'b1);
    push_item(REQ_B1, 0, 16'h8000, 1'b0);
    push_item(REQ_W2, 0, 16'h7FFF, 1'b0);
    push_item(REQ_B2, 0, 16'h8000, 1'b0);
    push_item(REQ_FEAT, 0, 16'h7FFF, 1'b1);
    // All-zero output: the negative bias wins, the result is emitted unscaled.
    push_item(REQ_B2, 0, 16'h8000, 1'b0);
    push_item(REQ_B1, 0, 16'h7FFF, 1'b0);
    push_item(REQ_FEAT, 0, 16'h8000, 1'b1);
    push_item(REQ_W1, 0, 16'h8000, 1'b0);
    push_item(REQ_B1, N_HID, 16'h1234, 1'b0);
    push_item(REQ_B2, N_OUT, 16'h1234, 1'b0);
    push_item(REQ_W2, 2047, 16'h1234, 1'b0);
    push_item(REQ_SPARE_LO, 3, 16'h1111, 1'b1);
    push_item(REQ_SPARE_HI, 2047, 16'hFFFF, 1'b1);
    push_item(REQ_B2, 0, 16'h0100, 1'b1);
    // Final feature on an out-of-range slot still runs on a cleared buffer.
    push_item(REQ_FEAT, 2047, 16'h4000, 1'b1);
    push_item(REQ_FEAT, 0, 16'h8000, 1'b0);
    push_item(REQ_FEAT, N_IN - 1, 16'h7FFF, 1'b0);
    push_item(REQ_FEAT, 0, 16'h0800, 1'b1);
    wait_drained();

    // Register values outside the legal range clamp to the nearest limit.
    set_dims(0, 0, 0);
    push_item(REQ_FEAT, 0, 16'h1000, 1'b1);
    wait_drained();
    set_dims(127, 1, 1);
    send_vector(N_IN, 1'b0);
    wait_drained();
    set_dims(1, 63, 1);
    send_vector(1, 1'b0);
    wait_drained();
    set_dims(1, 1, 31);
    send_vector(1, 1'b0);
    wait_drained();

    // Random phases with small dimensions inside the loaded weights.
    while (rand_items < RAND_ITEMS) begin
      gap_on = $urandom_range(0, 3) != 0;
      stall_on = $urandom_range(0, 3) != 0;
      ni = $urandom_range(1, 8);
      nh = $urandom_range(1, 4);
      no = $urandom_range(1, 8);
      set_dims(ni, nh, no);
      nvec = $urandom_range(2, 5);
      for (int v = 0; v < nvec; v++) begin
        send_noise($urandom_range(0, 4));
        send_vector(ni, 1'b1);
        // Once per phase or so, let the pipeline drain between vectors.
        if ($urandom_range(0, 3) == 0) wait_drained();
      end
      wait_drained();
    end

    wait_drained();
    if (err_cnt == 0 && emb_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: mlp_embedding_relu_l2norm.f
hdl/mlpemb_pkg.sv
hdl/mlp_embedding_relu_l2norm.sv
tb/tb_top.sv
